>>> design/vliw_bundle_nop_compressor_defines.svh
// ---------------------------------------------------------------------------
// vliw_bundle_nop_compressor_defines.svh
// Assertion macros for the VLIW bundle NOP compressor.
// ---------------------------------------------------------------------------
`ifndef VLIW_BUNDLE_NOP_COMPRESSOR_DEFINES_SVH
`define VLIW_BUNDLE_NOP_COMPRESSOR_DEFINES_SVH

`ifndef SYNTH
// antecedent |-> consequent, sampled on clk, off during reset
`define VBNC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent |=> consequent, sampled on clk, off during reset
`define VBNC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VBNC_ASSERT_IMP(lbl, ante, cons, msg)
`define VBNC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/vbnc_pkg.sv
// ---------------------------------------------------------------------------
// vbnc_pkg
// Shared constants, types and helpers for the VLIW bundle NOP compressor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vbnc_pkg;

    localparam int MAX_SLOTS  = 8;
    localparam int OP_BITS    = 32;
    localparam int HDR_W      = 24;
    localparam int HLEN_W     = 5;
    localparam int CNT_W      = 4;
    localparam int IDX_W      = 3;
    localparam int TOT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int DW_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ENCODE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ISSUE_WIDTH = 1'd1;

    localparam logic MODE_MASKED   = 1'b0;
    localparam logic MODE_TEMPLATE = 1'b1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_OP     = 1'b1;

    typedef struct packed {
        logic             accept;
        logic             load_hdr;
        logic             load_op;
        logic             clear;
        logic [IDX_W-1:0] rd_idx;
        logic             rd_last;
    } vbnc_cmd_t;

    typedef struct packed {
        logic             out_free;
        logic [CNT_W-1:0] kept_count;
    } vbnc_stat_t;

    // template delta field width: ceil(log2(issue_width)), 0 as 1, 9..15 as 8
    function automatic logic [DW_W-1:0] delta_width(input logic [CFG_DATA_W-1:0] w);
        logic [DW_W-1:0] r;
        if (w <= 4'd1)
        begin
            r = 2'd0;
        end
        else if (w == 4'd2)
        begin
            r = 2'd1;
        end
        else if (w <= 4'd4)
        begin
            r = 2'd2;
        end
        else
        begin
            r = 2'd3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/vbnc_ctrl.sv
// ---------------------------------------------------------------------------
// vbnc_ctrl
// Sequencer: takes slots, then drains header and kept words to the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vbnc_ctrl
    import vbnc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       bundle_end,
    input  vbnc_stat_t      stat,
    output vbnc_cmd_t       cmd
);

    localparam logic [1:0] S_ACCEPT = 2'd0;
    localparam logic [1:0] S_HDR    = 2'd1;
    localparam logic [1:0] S_OPS    = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             accept;
    logic             rd_last;

    assign in_ready = (state_reg == S_ACCEPT);
    assign accept   = in_valid && in_ready;
    assign rd_last  = (({1'b0, idx_reg} + CNT_W'(1)) == stat.kept_count);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.accept   = accept;
        cmd.load_hdr = 1'b0;
        cmd.load_op  = 1'b0;
        cmd.clear    = 1'b0;
        cmd.rd_idx   = idx_reg;
        cmd.rd_last  = rd_last;
        case (state_reg)
            S_ACCEPT:
            begin
                if (accept && bundle_end)
                begin
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_hdr = 1'b1;
                    idx_next     = '0;
                    if (stat.kept_count == '0)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_ACCEPT;
                    end
                    else
                    begin
                        state_next = S_OPS;
                    end
                end
            end
            S_OPS:
            begin
                if (stat.out_free)
                begin
                    cmd.load_op = 1'b1;
                    idx_next    = idx_reg + IDX_W'(1);
                    if (rd_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCEPT;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

>>> design/vbnc_datapath.sv
// ---------------------------------------------------------------------------
// vbnc_datapath
// Config registers, header builder, kept-word buffer and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vbnc_datapath
    import vbnc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [OP_BITS-1:0]    op_word,
    input  wire logic                  is_nop,
    input  vbnc_cmd_t                  cmd,
    output vbnc_stat_t                 stat,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       item_kind,
    output logic [HDR_W-1:0]           header_bits,
    output logic [HLEN_W-1:0]          header_len,
    output logic [OP_BITS-1:0]         kept_op,
    output logic [TOT_W-1:0]           total_bits,
    output logic                       last_of_bundle
);

    logic                  mode_reg;
    logic [CFG_DATA_W-1:0] width_reg;

    logic [OP_BITS-1:0]    kept_ops [MAX_SLOTS];
    logic [CNT_W-1:0]      kept_count_reg, kept_count_next;
    logic [CNT_W-1:0]      slot_index_reg, slot_index_next;
    logic [IDX_W-1:0]      last_kept_reg, last_kept_next;
    logic [HDR_W-1:0]      header_acc_reg, header_acc_next;
    logic [HLEN_W-1:0]     header_count_reg, header_count_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  kind_reg;
    logic [HDR_W-1:0]      hbits_reg;
    logic [HLEN_W-1:0]     hlen_reg;
    logic [OP_BITS-1:0]    op_reg;
    logic                  last_reg;

    logic                  slot_ok;
    logic                  keep;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W-1:0]      delta;
    logic [DW_W-1:0]       app_n;
    logic [IDX_W-1:0]      app_bits;
    logic                  app_ok;
    logic [HDR_W-1:0]      acc_shifted;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

    assign slot_ok = (slot_index_reg < CNT_W'(MAX_SLOTS));
    assign keep    = !is_nop && (kept_count_reg < CNT_W'(MAX_SLOTS));
    assign slot    = slot_index_reg[IDX_W-1:0];
    assign delta   = slot - last_kept_reg;

    always_comb
    begin
        app_n    = '0;
        app_bits = '0;
        if (mode_reg == MODE_MASKED)
        begin
            app_n    = DW_W'(1);
            app_bits = {{(IDX_W-1){1'b0}}, !is_nop};
        end
        else if (!is_nop)
        begin
            app_n    = delta_width(width_reg);
            app_bits = delta;
        end
    end

    assign app_ok = (app_n != '0)
                 && ((header_count_reg + HLEN_W'(app_n)) <= HLEN_W'(HDR_W));

    always_comb
    begin
        case (app_n)
            2'd1:    acc_shifted = {header_acc_reg[HDR_W-2:0], app_bits[0]};
            2'd2:    acc_shifted = {header_acc_reg[HDR_W-3:0], app_bits[1:0]};
            2'd3:    acc_shifted = {header_acc_reg[HDR_W-4:0], app_bits};
            default: acc_shifted = header_acc_reg;
        endcase
    end

    always_comb
    begin
        kept_count_next   = kept_count_reg;
        slot_index_next   = slot_index_reg;
        last_kept_next    = last_kept_reg;
        header_acc_next   = header_acc_reg;
        header_count_next = header_count_reg;
        total_next        = total_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (cmd.accept && slot_ok)
        begin
            if (app_ok)
            begin
                header_acc_next   = acc_shifted;
                header_count_next = header_count_reg + HLEN_W'(app_n);
            end
            if (keep)
            begin
                kept_count_next = kept_count_reg + CNT_W'(1);
                last_kept_next  = slot;
            end
            slot_index_next = slot_index_reg + CNT_W'(1);
        end
        if (cmd.load_hdr)
        begin
            total_next     = sat_add(total_reg, TOT_W'(header_count_reg));
            out_valid_next = 1'b1;
        end
        if (cmd.load_op)
        begin
            total_next     = sat_add(total_reg, TOT_W'(OP_BITS));
            out_valid_next = 1'b1;
        end
        if (cmd.clear)
        begin
            kept_count_next   = '0;
            slot_index_next   = '0;
            last_kept_next    = '0;
            header_acc_next   = '0;
            header_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_MASKED;
            width_reg        <= CFG_DATA_W'(4);
            kept_count_reg   <= '0;
            slot_index_reg   <= '0;
            last_kept_reg    <= '0;
            header_acc_reg   <= '0;
            header_count_reg <= '0;
            total_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENCODE_MODE: mode_reg  <= cfg_wdata[0];
                    REG_ISSUE_WIDTH: width_reg <= cfg_wdata;
                    default:         ;
                endcase
            end
            kept_count_reg   <= kept_count_next;
            slot_index_reg   <= slot_index_next;
            last_kept_reg    <= last_kept_next;
            header_acc_reg   <= header_acc_next;
            header_count_reg <= header_count_next;
            total_reg        <= total_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // kept-word buffer
    always_ff @(posedge clk)
    begin
        if (cmd.accept && slot_ok && keep)
        begin
            kept_ops[kept_count_reg[IDX_W-1:0]] <= op_word;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.load_hdr)
        begin
            kind_reg  <= KIND_HEADER;
            hbits_reg <= header_acc_reg;
            hlen_reg  <= header_count_reg;
            op_reg    <= '0;
            last_reg  <= (kept_count_reg == '0);
        end
        else if (cmd.load_op)
        begin
            kind_reg  <= KIND_OP;
            hbits_reg <= '0;
            hlen_reg  <= '0;
            op_reg    <= kept_ops[cmd.rd_idx];
            last_reg  <= cmd.rd_last;
        end
    end

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.kept_count = kept_count_reg;

    assign out_valid      = out_valid_reg;
    assign item_kind      = kind_reg;
    assign header_bits    = hbits_reg;
    assign header_len     = hlen_reg;
    assign kept_op        = op_reg;
    assign total_bits     = total_reg;
    assign last_of_bundle = last_reg;

endmodule

`default_nettype wire

>>> design/vliw_bundle_nop_compressor.sv
// ---------------------------------------------------------------------------
// vliw_bundle_nop_compressor
// Drops NOP slots from VLIW bundles; emits a header word and the kept ops.
// ---------------------------------------------------------------------------
// channel | signals                         | dir | payload
// --------+---------------------------------+-----+---------------------------
// in      | in_valid / in_ready             | in  | op_word, is_nop, bundle_end
// out     | out_valid / out_ready           | out | item_kind, header_bits,
//         |                                 |     | header_len, kept_op,
//         |                                 |     | total_bits, last_of_bundle
// cfg     | cfg_we, cfg_index, cfg_wdata    | in  | encode_mode, issue_width
//
// One slot word is taken per cycle. A word with bundle_end is followed by
// 1 + kept words of output, one per cycle from the output register, during
// which no slot is taken. A stalled output holds the sequencer. Reset clears
// all control state and restores encode_mode 0 and issue_width 4; no
// clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vliw_bundle_nop_compressor_defines.svh"

module vliw_bundle_nop_compressor
    import vbnc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OP_BITS-1:0]    op_word,
    input  wire logic                  is_nop,
    input  wire logic                  bundle_end,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       item_kind,
    output logic [HDR_W-1:0]           header_bits,
    output logic [HLEN_W-1:0]          header_len,
    output logic [OP_BITS-1:0]         kept_op,
    output logic [TOT_W-1:0]           total_bits,
    output logic                       last_of_bundle
);

    vbnc_cmd_t  cmd;
    vbnc_stat_t stat;

    vbnc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .bundle_end (bundle_end),
        .stat       (stat),
        .cmd        (cmd)
    );

    vbnc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .op_word        (op_word),
        .is_nop         (is_nop),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_kind      (item_kind),
        .header_bits    (header_bits),
        .header_len     (header_len),
        .kept_op        (kept_op),
        .total_bits     (total_bits),
        .last_of_bundle (last_of_bundle)
    );

    `VBNC_ASSERT_IMP(a_hdr_len, out_valid && (item_kind == KIND_HEADER), header_len <= HLEN_W'(HDR_W) && kept_op == '0, "header word too long or carries an op")
    `VBNC_ASSERT_IMP(a_op_zero_hdr, out_valid && (item_kind == KIND_OP), header_len == '0 && header_bits == '0, "op word carries header bits")
    `VBNC_ASSERT_NEXT(a_total_mono, out_valid && out_ready, !out_valid || (total_bits >= $past(total_bits)), "running total went down")

endmodule

`default_nettype wire

>>> sim/vliw_bundle_nop_compressor_test.sv
// ---------------------------------------------------------------------------
// vliw_bundle_nop_compressor_test
// Self-checking bench for the VLIW bundle NOP compressor.
//
// A short table of directed bundles goes first: masked and template headers,
// NOP-only bundles, overlong bundles, truncated deltas and out-of-range
// widths. Random bundles follow, over several register settings and with
// sender gaps and receiver stalls. An internal model predicts every output
// word, with the header words of directed bundles taken from the table, and
// each word out is compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vliw_bundle_nop_compressor_test;

    import vbnc_pkg::*;

    localparam int MAX_RESULTS    = MAX_SLOTS + 1;
    localparam int NUM_DIRECTED   = 31;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_SLOTS    = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic PHASE_MODE [NUM_PHASES] = '{MODE_MASKED, MODE_TEMPLATE,
        MODE_TEMPLATE, MODE_MASKED, MODE_TEMPLATE, MODE_TEMPLATE, MODE_MASKED,
        MODE_TEMPLATE};
    localparam logic [CFG_DATA_W-1:0] PHASE_WIDTH [NUM_PHASES] = '{4'd4, 4'd8,
        4'd3, 4'd1, 4'd1, 4'd12, 4'd15, 4'd6};

    typedef enum logic {ROW_SLOT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [OP_BITS-1:0]    op;
        logic                  nop;
        logic                  last;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  known;
        logic [HDR_W-1:0]      hbits;
        logic [HLEN_W-1:0]     hlen;
        logic [TOT_W-1:0]      total;
    } stim_row_t;

    typedef struct packed {
        logic               kind;
        logic [HDR_W-1:0]   hbits;
        logic [HLEN_W-1:0]  hlen;
        logic [OP_BITS-1:0] op;
        logic [TOT_W-1:0]   total;
        logic               last;
    } bundle_word_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_ENCODE_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [OP_BITS-1:0]    op_word     = '0;
    logic                  is_nop      = 1'b0;
    logic                  bundle_end  = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  item_kind;
    logic [HDR_W-1:0]      header_bits;
    logic [HLEN_W-1:0]     header_len;
    logic [OP_BITS-1:0]    kept_op;
    logic [TOT_W-1:0]      total_bits;
    logic                  last_of_bundle;

    // compressor model state
    logic                  cur_mode   = MODE_MASKED;
    logic [CFG_DATA_W-1:0] cur_width  = 4'd4;
    logic [OP_BITS-1:0]    kept_buf [MAX_SLOTS];
    logic [CNT_W-1:0]      kept_cnt   = '0;
    logic [CNT_W-1:0]      slot_pos   = '0;
    logic [IDX_W-1:0]      last_kept  = '0;
    logic [HDR_W-1:0]      hdr_acc    = '0;
    logic [HLEN_W-1:0]     hdr_cnt    = '0;
    logic [TOT_W-1:0]      size_sum   = '0;

    bundle_word_t bundle_words [MAX_RESULTS];
    bundle_word_t queued_words [$];
    stim_row_t    directed_rows [NUM_DIRECTED];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int slots_taken    = 0;
    int bundles_done   = 0;
    int words_seen     = 0;
    int reg_writes     = 0;
    int quiet_cycles   = 0;

    vliw_bundle_nop_compressor u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op_word        (op_word),
        .is_nop         (is_nop),
        .bundle_end     (bundle_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_kind      (item_kind),
        .header_bits    (header_bits),
        .header_len     (header_len),
        .kept_op        (kept_op),
        .total_bits     (total_bits),
        .last_of_bundle (last_of_bundle)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // delta field: 0 bits for one slot or fewer, 3 bits for five or more
    function automatic int delta_field_bits(input logic [CFG_DATA_W-1:0] w);
        int r;
        case (w)
            4'd0, 4'd1: r = 0;
            4'd2:       r = 1;
            4'd3, 4'd4: r = 2;
            default:    r = 3;
        endcase
        return r;
    endfunction

    function automatic void append_hdr(input logic [31:0] bits, input int n);
        logic [31:0] field;
        if (n != 0 && int'(hdr_cnt) + n <= HDR_W)
        begin
            field   = bits & ((32'd1 << n) - 32'd1);
            hdr_acc = HDR_W'(({8'd0, hdr_acc} << n) | field);
            hdr_cnt = hdr_cnt + HLEN_W'(n);
        end
    endfunction

    function automatic void add_size(input logic [TOT_W-1:0] n);
        logic [TOT_W:0] s;
        s        = {1'b0, size_sum} + {1'b0, n};
        size_sum = s[TOT_W] ? '1 : s[TOT_W-1:0];
    endfunction

    // advances the model by one slot word; fills bundle_words, returns count
    function automatic int compress_slot(input logic [OP_BITS-1:0] op, input logic nop,
                                         input logic last);
        int n;
        if (int'(slot_pos) < MAX_SLOTS)
        begin
            if (cur_mode == MODE_MASKED)
            begin
                append_hdr(32'(!nop), 1);
            end
            else if (!nop)
            begin
                append_hdr(32'(slot_pos - {1'b0, last_kept}), delta_field_bits(cur_width));
            end
            if (!nop && int'(kept_cnt) < MAX_SLOTS)
            begin
                kept_buf[kept_cnt[IDX_W-1:0]] = op;
                kept_cnt  = kept_cnt + 1'b1;
                last_kept = slot_pos[IDX_W-1:0];
            end
            slot_pos = slot_pos + 1'b1;
        end
        if (!last)
        begin
            return 0;
        end
        add_size(TOT_W'(hdr_cnt));
        bundle_words[0] = '{KIND_HEADER, hdr_acc, hdr_cnt, '0, size_sum, kept_cnt == '0};
        for (int i = 0; i < int'(kept_cnt); i++)
        begin
            add_size(TOT_W'(OP_BITS));
            bundle_words[i + 1] = '{KIND_OP, '0, '0, kept_buf[i], size_sum,
                                    i + 1 == int'(kept_cnt)};
        end
        n         = int'(kept_cnt) + 1;
        kept_cnt  = '0;
        slot_pos  = '0;
        last_kept = '0;
        hdr_acc   = '0;
        hdr_cnt   = '0;
        return n;
    endfunction

    task automatic send_slot(input stim_row_t row);
        int n;
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid   <= 1'b1;
        op_word    <= row.op;
        is_nop     <= row.nop;
        bundle_end <= row.last;
        do @(posedge clk); while (in_ready !== 1'b1);
        slots_taken++;
        n = compress_slot(row.op, row.nop, row.last);
        if (n != 0)
        begin
            bundles_done++;
            if (row.known)
            begin
                bundle_words[0].hbits = row.hbits;
                bundle_words[0].hlen  = row.hlen;
                bundle_words[0].total = row.total;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            queued_words.insert(queued_words.size(), bundle_words[i]);
        end
    endtask

    // waits for the block to drain, then writes one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (queued_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ENCODE_MODE)
        begin
            cur_mode = data[0];
        end
        else
        begin
            cur_width = data;
        end
        reg_writes++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        bundle_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (queued_words.size() == 0)
            begin
                $display("%0t: output word with none due, expected nothing, actual kind %0d op %0h",
                         $time, item_kind, kept_op);
                mismatches++;
            end
            else
            begin
                want = queued_words.pop_front();
                check_field("item_kind", 32'(want.kind), 32'(item_kind));
                check_field("header_bits", 32'(want.hbits), 32'(header_bits));
                check_field("header_len", 32'(want.hlen), 32'(header_len));
                check_field("kept_op", want.op, kept_op);
                check_field("total_bits", want.total, total_bits);
                check_field("last_of_bundle", 32'(want.last), 32'(last_of_bundle));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        stim_row_t          row;
        logic [OP_BITS-1:0] op;
        int                 sent;
        int                 len;
        int                 eff;

        directed_rows = '{
            // first bundle after reset, masked, header 101
            '{ROW_SLOT, 32'hFFFF_FFFF, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'hFFFF_FFFF, 1'b1, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0000_0000, 1'b0, 1'b1, REG_ENCODE_MODE, 4'd0, 1'b1, 24'h5, 5'd3, 32'd3},
            // NOP-only bundle: lone header closes it
            '{ROW_SLOT, 32'h0000_0000, 1'b1, 1'b1, REG_ENCODE_MODE, 4'd0, 1'b1, 24'h0, 5'd1, 32'd68},
            // nine slots, the ninth is dropped
            '{ROW_SLOT, 32'h0000_0001, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0000_0002, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h8000_0000, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h7FFF_FFFF, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h5555_5555, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'hAAAA_AAAA, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h1234_5678, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'hFEDC_BA98, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'hFFFF_FFFF, 1'b0, 1'b1, REG_ENCODE_MODE, 4'd0, 1'b1, 24'hFF, 5'd8, 32'd76},
            // template mode, 1-bit deltas: distance 3 truncates to 1
            '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, REG_ENCODE_MODE, 4'hF, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, REG_ISSUE_WIDTH, 4'd2, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0000_0000, 1'b1, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0000_0000, 1'b1, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0000_0000, 1'b1, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0000_0001, 1'b0, 1'b1, REG_ENCODE_MODE, 4'd0, 1'b1, 24'h1, 5'd1, 32'd333},
            // width 0 acts as 1: empty header
            '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, REG_ISSUE_WIDTH, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'hC001_D00D, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h3FFE_0001, 1'b0, 1'b1, REG_ENCODE_MODE, 4'd0, 1'b1, 24'h0, 5'd0, 32'd365},
            // width 15 acts as 8: full 24-bit header
            '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, REG_ISSUE_WIDTH, 4'hF, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0101_0101, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0202_0202, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0303_0303, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0404_0404, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0505_0505, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0606_0606, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0707_0707, 1'b0, 1'b0, REG_ENCODE_MODE, 4'd0, 1'b0, 24'h0, 5'd0, 32'd0},
            '{ROW_SLOT, 32'h0808_0808, 1'b0, 1'b1, REG_ENCODE_MODE, 4'd0, 1'b1, 24'h049249, 5'd24,
              32'd453}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            end
            else
            begin
                send_slot(directed_rows[r]);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph / 2)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            write_reg(REG_ENCODE_MODE, {3'($urandom_range(7)), PHASE_MODE[ph]});
            write_reg(REG_ISSUE_WIDTH, PHASE_WIDTH[ph]);
            eff  = (cur_width == '0) ? 1 : (int'(cur_width) > MAX_SLOTS) ? MAX_SLOTS
                                                                         : int'(cur_width);
            sent = 0;
            while (sent < PHASE_SLOTS)
            begin
                // mostly bundles that fit the issue width, some overlong
                len = ($urandom_range(4) == 0) ? $urandom_range(11, 1) : $urandom_range(eff, 1);
                for (int s = 0; s < len; s++)
                begin
                    case ($urandom_range(9))
                        0:       op = '0;
                        1:       op = '1;
                        default: op = $urandom;
                    endcase
                    row       = '0;
                    row.kind  = ROW_SLOT;
                    row.op    = op;
                    row.nop   = ($urandom_range(99) < 40);
                    row.last  = (s == len - 1);
                    send_slot(row);
                end
                sent += len;
            end
        end

        in_valid <= 1'b0;
        while (queued_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d slot words in %0d bundles, %0d register writes,",
                 slots_taken, bundles_done, reg_writes);
        $display("masked and template headers, %0d output words checked.", words_seen);
        if (mismatches == 0 && queued_words.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/vbnc_pkg.sv
design/vbnc_ctrl.sv
design/vbnc_datapath.sv
design/vliw_bundle_nop_compressor.sv
sim/vliw_bundle_nop_compressor_test.sv
